FILE: sv/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  localparam int KIND_W = 2;
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [KIND_W-1:0] KIND_PLAIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COLORED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef struct packed {
    logic accept;
    logic scr_rd;
    logic scr_wr;
    logic fill_wr;
    logic init_attr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SWR  = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.fill_wr   = 1'b1;
        cmd_o.init_attr = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_clear) state_d = S_CLR;
          else if (sts_i.need_scroll) state_d = S_SRD;
          else state_d = S_DONE;
        end
      end
      S_CLR, S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) state_d = S_DONE;
      end
      S_SRD: begin
        cmd_o.scr_rd = 1'b1;
        state_d      = S_SWR;
      end
      S_SWR: begin
        cmd_o.scr_wr = 1'b1;
        state_d      = sts_i.copy_last ? S_FILL : S_SRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/tcw_datapath.sv
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [ATTR_W-1:0] color_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [ATTR_W-1:0] def_attr_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [POS_W-1:0]  pos_o,
  output logic [CELL_W-1:0] cell_o,
  output logic              scrolled_o
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W + 1 : IDX_W + 1;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PH_W-1:0]   ph_q, ph_d;
  logic [ADDR_W-1:0] swp_q;
  logic              scr_q, isrd_q, rdok_q;
  logic              out_valid_q;
  logic [POS_W-1:0]  pos_q;
  logic [CELL_W-1:0] cell_q;
  logic              scrolled_q;

  logic              store;
  logic [ATTR_W-1:0] st_attr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W+ROW_W:0] cur_lin;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [CELL_W-1:0] wd;
  logic              is_char;

  assign is_char = (kind_i == KIND_PLAIN) || (kind_i == KIND_COLORED);
  assign cur_lin = (ADDR_W+ROW_W+1)'(row_q) * (ADDR_W+ROW_W+1)'(COLUMNS)
                 + (ADDR_W+ROW_W+1)'(col_q);
  assign cur_addr = cur_lin[ADDR_W-1:0];

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    ph_d    = ph_q;
    store   = 1'b0;
    st_attr = def_attr_i;
    if (code_i == CH_BS) begin
      if (col_q != '0) begin
        col_d = col_q - 1'b1;
        ph_d  = (ph_q == '0) ? PH_W'(TAB_WIDTH - 1) : ph_q - 1'b1;
      end
    end else if (code_i == CH_TAB) begin
      col_d = col_q + COL_W'(TAB_WIDTH) - COL_W'(ph_q);
      ph_d  = '0;
    end else if (code_i == CH_CR) begin
      col_d = '0;
      ph_d  = '0;
    end else if (code_i == CH_LF) begin
      col_d = '0;
      ph_d  = '0;
      row_d = row_q + 1'b1;
    end else if (kind_i == KIND_PLAIN ||
                 (code_i >= CH_SPACE && code_i <= CH_LAST)) begin
      store   = 1'b1;
      st_attr = (kind_i == KIND_PLAIN) ? def_attr_i : color_i;
      col_d   = col_q + 1'b1;
      ph_d    = (ph_q == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_q + 1'b1;
    end
    if (col_d >= COL_W'(COLUMNS)) begin
      col_d = '0;
      ph_d  = '0;
      row_d = row_d + 1'b1;
    end
  end

  assign sts_o.is_clear    = (kind_i == KIND_CLEAR);
  assign sts_o.need_scroll = is_char && (row_d >= ROW_W'(ROWS));
  assign sts_o.copy_last   = (swp_q == ADDR_W'(COPY_N - 1));
  assign sts_o.fill_last   = (swp_q == ADDR_W'(CELLS - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    we = 1'b0;
    wa = swp_q;
    wd = rd_q;
    if (cmd_i.accept && is_char && store) begin
      we = 1'b1;
      wa = cur_addr;
      wd = {st_attr, code_i};
    end else if (cmd_i.scr_wr) begin
      we = 1'b1;
    end else if (cmd_i.fill_wr) begin
      we = 1'b1;
      wd = {(cmd_i.init_attr ? RESET_ATTR : def_attr_i), CH_SPACE};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.scr_rd) begin
      rd_q <= mem[ADDR_W'(swp_q + ADDR_W'(COLUMNS))];
    end else if (cmd_i.accept && kind_i == KIND_READ) begin
      rd_q <= mem[ADDR_W'(idx_i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      ph_q        <= '0;
      swp_q       <= '0;
      scr_q       <= 1'b0;
      isrd_q      <= 1'b0;
      rdok_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        swp_q  <= '0;
        isrd_q <= (kind_i == KIND_READ);
        rdok_q <= (CMP_W'(idx_i) < CMP_W'(CELLS));
        scr_q  <= sts_o.need_scroll;
        if (kind_i == KIND_CLEAR) begin
          col_q <= '0;
          row_q <= '0;
          ph_q  <= '0;
        end else if (is_char) begin
          col_q <= col_d;
          ph_q  <= ph_d;
          row_q <= sts_o.need_scroll ? ROW_W'(ROWS - 1) : row_d;
        end
      end else if (cmd_i.scr_wr || cmd_i.fill_wr) begin
        swp_q <= swp_q + 1'b1;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_q      <= POS_W'(cur_lin);
      cell_q     <= (isrd_q && rdok_q) ? rd_q : '0;
      scrolled_q <= scr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_o       = pos_q;
  assign cell_o      = cell_q;
  assign scrolled_o  = scrolled_q;

endmodule

FILE: sv/text_console_writer.sv
// Character and read items go from the idle state through the done state to the
// output register, waiting in the done state while the output is stalled. A scroll
// first copies (ROWS-1)*COLUMNS cells up one row (a read and a write state per cell
// over one shared store port), then fills the last row; a clear fills all ROWS*COLUMNS
// cells. One item at a time. Reset: cursor home, attribute 0x0F; a clearing pass over
// all ROWS*COLUMNS cells fills the store with 0x0F20 before the first item is taken.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], color_attribute[15:8], cell_index[26:16]
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_position[10:0], cell_value[26:11], scrolled[27]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [ATTR_W-1:0] attr_q;
  cmd_t              cmd;
  sts_t              sts;
  logic [POS_W-1:0]  pos;
  logic [CELL_W-1:0] cell_val;
  logic              scrolled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .kind_i      (s_axis_tuser),
    .code_i      (s_axis_tdata[7:0]),
    .color_i     (s_axis_tdata[15:8]),
    .idx_i       (s_axis_tdata[26:16]),
    .def_attr_i  (attr_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .pos_o       (pos),
    .cell_o      (cell_val),
    .scrolled_o  (scrolled)
  );

  assign m_axis_tdata = {4'd0, scrolled, cell_val, pos};

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted back to back");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CLEAR) |=> ##1 !s_axis_tready)
    else $error("clear finished too early");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output overwritten");

endmodule
